@@ hdl/stt_pkg.sv @@
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, token kind codes and the keyword table of the tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int unsigned NUM_KW            = 20;
  localparam int unsigned KW_MAX_LEN        = 9;
  localparam int unsigned POSITION_BITS_DEF = 16;
  localparam int unsigned LENGTH_BITS_DEF   = 16;

  typedef logic [4:0] kind_t;
  typedef logic [1:0] err_t;

  localparam kind_t KIND_END     = 5'd0;
  localparam kind_t KIND_IDENT   = 5'd1;
  localparam kind_t KIND_INT     = 5'd2;
  localparam kind_t KIND_STRING  = 5'd3;
  localparam kind_t KIND_ARROW   = 5'd4;
  localparam kind_t KIND_EQEQ    = 5'd5;
  localparam kind_t KIND_NOTEQ   = 5'd6;
  localparam kind_t KIND_LBRACE  = 5'd7;
  localparam kind_t KIND_RBRACE  = 5'd8;
  localparam kind_t KIND_LPAREN  = 5'd9;
  localparam kind_t KIND_RPAREN  = 5'd10;
  localparam kind_t KIND_COMMA   = 5'd11;
  localparam kind_t KIND_DOT     = 5'd12;
  localparam kind_t KIND_COLON   = 5'd13;
  localparam kind_t KIND_SEMI    = 5'd14;
  localparam kind_t KIND_PLUS    = 5'd15;
  localparam kind_t KIND_MINUS   = 5'd16;
  localparam kind_t KIND_ASSIGN  = 5'd17;
  localparam kind_t KIND_KEYWORD = 5'd18;
  localparam kind_t KIND_ERROR   = 5'd19;

  localparam err_t ERR_NONE       = 2'd0;
  localparam err_t ERR_UNEXPECTED = 2'd1;
  localparam err_t ERR_UNTERM_STR = 2'd2;

  typedef struct packed {
    kind_t       kind;
    logic [4:0]  keyword_index;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [15:0] token_length;
    err_t        error_code;
    logic [7:0]  bad_char;
    logic        last;
  } result_t;

  // Keyword text, first character in the top byte, zero padded.
  function automatic logic [8*KW_MAX_LEN-1:0] kw_word(input logic [4:0] k);
    case (k)
      5'd0:    kw_word = {"struct",    24'h0};
      5'd1:    kw_word = {"class",     32'h0};
      5'd2:    kw_word = {"entity",    24'h0};
      5'd3:    kw_word = "component";
      5'd4:    kw_word = {"mut",       48'h0};
      5'd5:    kw_word = {"fn",        56'h0};
      5'd6:    kw_word = {"let",       48'h0};
      5'd7:    kw_word = {"ref",       48'h0};
      5'd8:    kw_word = {"if",        56'h0};
      5'd9:    kw_word = {"else",      40'h0};
      5'd10:   kw_word = {"while",     32'h0};
      5'd11:   kw_word = {"for",       48'h0};
      5'd12:   kw_word = {"return",    24'h0};
      5'd13:   kw_word = {"true",      40'h0};
      5'd14:   kw_word = {"false",     32'h0};
      5'd15:   kw_word = {"void",      40'h0};
      5'd16:   kw_word = {"int",       48'h0};
      5'd17:   kw_word = {"float",     32'h0};
      5'd18:   kw_word = {"bool",      40'h0};
      5'd19:   kw_word = {"string",    24'h0};
      default: kw_word = '0;
    endcase
  endfunction

  function automatic logic [3:0] kw_len(input logic [4:0] k);
    case (k)
      5'd0:    kw_len = 4'd6;
      5'd1:    kw_len = 4'd5;
      5'd2:    kw_len = 4'd6;
      5'd3:    kw_len = 4'd9;
      5'd4:    kw_len = 4'd3;
      5'd5:    kw_len = 4'd2;
      5'd6:    kw_len = 4'd3;
      5'd7:    kw_len = 4'd3;
      5'd8:    kw_len = 4'd2;
      5'd9:    kw_len = 4'd4;
      5'd10:   kw_len = 4'd5;
      5'd11:   kw_len = 4'd3;
      5'd12:   kw_len = 4'd6;
      5'd13:   kw_len = 4'd4;
      5'd14:   kw_len = 4'd5;
      5'd15:   kw_len = 4'd4;
      5'd16:   kw_len = 4'd3;
      5'd17:   kw_len = 4'd5;
      5'd18:   kw_len = 4'd4;
      5'd19:   kw_len = 4'd6;
      default: kw_len = 4'd0;
    endcase
  endfunction

  // Character of keyword k at position pos; zero past its end.
  function automatic logic [7:0] kw_char(input logic [4:0] k, input logic [3:0] pos);
    logic [8*KW_MAX_LEN-1:0] w;
    logic [3:0]              back;
    w    = kw_word(k);
    back = 4'(KW_MAX_LEN - 1) - pos;
    if (pos < 4'(KW_MAX_LEN)) begin
      kw_char = w[{back, 3'b000} +: 8];
    end else begin
      kw_char = 8'h00;
    end
  endfunction

endpackage

@@ hdl/stt_in_if.sv @@
// ----------------------------------------------------------------------------
// stt_in_if
// Character channel: one source byte or an end-of-text mark per transfer.
// ----------------------------------------------------------------------------
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

@@ hdl/stt_out_if.sv @@
// ----------------------------------------------------------------------------
// stt_out_if
// Token channel: one token with position, length and error info per transfer.
// ----------------------------------------------------------------------------
interface stt_out_if;
  import stt_pkg::*;

  logic        valid;
  logic        ready;
  kind_t       kind;
  logic [4:0]  keyword_index;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic [15:0] token_length;
  err_t        error_code;
  logic [7:0]  bad_char;
  logic        last;

  modport source (output valid, output kind, output keyword_index, output start_line,
                  output start_column, output token_length, output error_code,
                  output bad_char, output last, input ready);
  modport sink   (input valid, input kind, input keyword_index, input start_line,
                  input start_column, input token_length, input error_code,
                  input bad_char, input last, output ready);
endinterface

@@ hdl/source_text_tokenizer_core.sv @@
// ----------------------------------------------------------------------------
// source_text_tokenizer_core
// Streaming tokenizer: source bytes in, tokens with position and length out.
// ----------------------------------------------------------------------------
// in_i carries one byte per transfer; end_of_text or a zero byte ends the
// text. out_o carries tokens; the last token caused by one input byte has
// last set. One byte is taken per cycle while in_i.ready is high: the
// scanner state and the tokens of a byte are computed in one pass and
// written into a two-entry token queue, each entry holding the one or
// two tokens of a byte. A token is registered in the queue with its byte
// and offered from the queue head. The two tokens of a byte (a flushed
// token plus a symbol, error or end token) leave in turn by its one port.
// in_i.ready drops while both queue entries are occupied, so a stalled
// receiver holds tokens in place and backs up the byte stream without loss.
// Reset empties the queue and puts the scanner at line 1, column 1; the end
// token of a text returns the scanner to that same state.
// ----------------------------------------------------------------------------
module source_text_tokenizer_core #(
  parameter int unsigned POSITION_BITS = stt_pkg::POSITION_BITS_DEF,
  parameter int unsigned LENGTH_BITS   = stt_pkg::LENGTH_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  stt_in_if.sink    in_i,
  stt_out_if.source out_o
);
  import stt_pkg::*;

  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_IDENT   = 4'd1;
  localparam logic [3:0] M_INT     = 4'd2;
  localparam logic [3:0] M_STRING  = 4'd3;
  localparam logic [3:0] M_MINUS   = 4'd4;
  localparam logic [3:0] M_EQ      = 4'd5;
  localparam logic [3:0] M_BANG    = 4'd6;
  localparam logic [3:0] M_SLASH   = 4'd7;
  localparam logic [3:0] M_COMMENT = 4'd8;
  localparam logic [3:0] M_ERROR   = 4'd9;

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [LENGTH_BITS-1:0]   len_t;

  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  function automatic pos_t pos_inc(input pos_t v);
    pos_inc = (&v) ? v : v + 1'b1;
  endfunction

  function automatic len_t len_inc(input len_t v);
    len_inc = (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [15:0] pos_out(input pos_t v);
    logic [31:0] w;
    w = 32'(v);
    pos_out = w[15:0];
  endfunction

  function automatic logic [15:0] len_out(input len_t v);
    logic [31:0] w;
    w = 32'(v);
    len_out = w[15:0];
  endfunction

  function automatic logic [NUM_KW-1:0] narrow(input logic [NUM_KW-1:0] cand,
                                               input len_t p, input logic [7:0] c);
    logic in_range;
    in_range = (p < LENGTH_BITS'(KW_MAX_LEN));
    for (int k = 0; k < NUM_KW; k++) begin
      narrow[k] = cand[k] && in_range && (kw_char(5'(k), p[3:0]) == c);
    end
  endfunction

  function automatic result_t mk(input kind_t kind, input logic [4:0] kwi,
                                 input pos_t line, input pos_t col,
                                 input logic [15:0] len, input err_t err,
                                 input logic [7:0] bad);
    mk.kind          = kind;
    mk.keyword_index = kwi;
    mk.start_line    = pos_out(line);
    mk.start_column  = pos_out(col);
    mk.token_length  = len;
    mk.error_code    = err;
    mk.bad_char      = bad;
    mk.last          = 1'b0;
  endfunction

  // scanner state
  logic [3:0]        mode_q, mode_d;
  pos_t              line_q, line_d;
  pos_t              col_q, col_d;
  pos_t              tsl_q, tsl_d;
  pos_t              tsc_q, tsc_d;
  len_t              cnt_q, cnt_d;
  logic [NUM_KW-1:0] cand_q, cand_d;

  // token queue
  entry_t     ent_q [2];
  logic       wr_q, rd_q, sub_q;
  logic [1:0] fill_q, fill_d;

  logic       accept, push, pop, out_xfer;
  logic [7:0] c;
  logic       eot, is_alpha, is_digit;

  // start-of-token decode
  logic [3:0]        bc_mode;
  len_t              bc_cnt;
  logic [NUM_KW-1:0] bc_cand;
  logic              bc_v;
  result_t           bc_res;

  // flushed identifier
  logic       kw_hit;
  logic [4:0] kw_idx;
  result_t    id_res;

  logic    a_v, b_v, use_bc;
  result_t a_res, b_res;
  entry_t  ent_new;

  assign c        = in_i.char_code;
  assign eot      = in_i.end_of_text || (c == 8'h00);
  assign is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c == "_");
  assign is_digit = (c >= "0" && c <= "9");

  assign in_i.ready = (fill_q != 2'd2);
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    bc_mode = M_IDLE;
    bc_cnt  = '0;
    bc_cand = cand_q;
    bc_v    = 1'b0;
    bc_res  = mk(KIND_END, 5'd0, line_q, col_q, 16'd1, ERR_NONE, 8'h00);
    if (c == " " || c == 8'h09 || c == 8'h0a || c == 8'h0d) begin
      bc_mode = M_IDLE;
    end else if (is_alpha) begin
      bc_cand = narrow('1, '0, c);
      bc_cnt  = LENGTH_BITS'(1);
      bc_mode = M_IDENT;
    end else if (is_digit) begin
      bc_cnt  = LENGTH_BITS'(1);
      bc_mode = M_INT;
    end else begin
      bc_v = 1'b1;
      case (c)
        "\"": begin bc_v = 1'b0; bc_mode = M_STRING; end
        "-":  begin bc_v = 1'b0; bc_mode = M_MINUS;  end
        "=":  begin bc_v = 1'b0; bc_mode = M_EQ;     end
        "!":  begin bc_v = 1'b0; bc_mode = M_BANG;   end
        "/":  begin bc_v = 1'b0; bc_mode = M_SLASH;  end
        "{":  bc_res.kind = KIND_LBRACE;
        "}":  bc_res.kind = KIND_RBRACE;
        "(":  bc_res.kind = KIND_LPAREN;
        ")":  bc_res.kind = KIND_RPAREN;
        ",":  bc_res.kind = KIND_COMMA;
        ".":  bc_res.kind = KIND_DOT;
        ":":  bc_res.kind = KIND_COLON;
        ";":  bc_res.kind = KIND_SEMI;
        "+":  bc_res.kind = KIND_PLUS;
        default: begin
          bc_res  = mk(KIND_ERROR, 5'd0, line_q, col_q, 16'd0, ERR_UNEXPECTED, c);
          bc_mode = M_ERROR;
        end
      endcase
    end
  end

  always_comb begin
    kw_hit = 1'b0;
    kw_idx = 5'd0;
    for (int k = 0; k < NUM_KW; k++) begin
      if (!kw_hit && cand_q[k] && (cnt_q == LENGTH_BITS'(kw_len(5'(k))))) begin
        kw_hit = 1'b1;
        kw_idx = 5'(k);
      end
    end
    if (kw_hit) begin
      id_res = mk(KIND_KEYWORD, kw_idx, tsl_q, tsc_q, len_out(cnt_q), ERR_NONE, 8'h00);
    end else begin
      id_res = mk(KIND_IDENT, 5'd0, tsl_q, tsc_q, len_out(cnt_q), ERR_NONE, 8'h00);
    end
  end

  always_comb begin
    mode_d = mode_q;
    line_d = line_q;
    col_d  = col_q;
    tsl_d  = tsl_q;
    tsc_d  = tsc_q;
    cnt_d  = cnt_q;
    cand_d = cand_q;
    a_v    = 1'b0;
    a_res  = mk(KIND_INT, 5'd0, tsl_q, tsc_q, len_out(cnt_q), ERR_NONE, 8'h00);
    b_v    = 1'b0;
    b_res  = bc_res;
    use_bc = 1'b0;
    if (eot) begin
      case (mode_q)
        M_IDENT:  begin a_v = 1'b1; a_res = id_res; end
        M_INT:    a_v = 1'b1;
        M_STRING: begin
          a_v   = 1'b1;
          a_res = mk(KIND_ERROR, 5'd0, tsl_q, tsc_q, 16'd0, ERR_UNTERM_STR, 8'h00);
        end
        M_MINUS:  begin
          a_v   = 1'b1;
          a_res = mk(KIND_MINUS, 5'd0, tsl_q, tsc_q, 16'd1, ERR_NONE, 8'h00);
        end
        M_EQ:     begin
          a_v   = 1'b1;
          a_res = mk(KIND_ASSIGN, 5'd0, tsl_q, tsc_q, 16'd1, ERR_NONE, 8'h00);
        end
        M_BANG:   begin
          a_v   = 1'b1;
          a_res = mk(KIND_ERROR, 5'd0, tsl_q, tsc_q, 16'd0, ERR_UNEXPECTED, "!");
        end
        M_SLASH:  begin
          a_v   = 1'b1;
          a_res = mk(KIND_ERROR, 5'd0, tsl_q, tsc_q, 16'd0, ERR_UNEXPECTED, "/");
        end
        default:  a_v = 1'b0;
      endcase
      b_v    = 1'b1;
      b_res  = mk(KIND_END, 5'd0, line_q, col_q, 16'd0, ERR_NONE, 8'h00);
      mode_d = M_IDLE;
      line_d = POSITION_BITS'(1);
      col_d  = POSITION_BITS'(1);
      tsl_d  = POSITION_BITS'(1);
      tsc_d  = POSITION_BITS'(1);
      cnt_d  = '0;
      cand_d = '1;
    end else begin
      case (mode_q)
        M_IDENT: begin
          if (is_alpha || is_digit) begin
            cand_d = narrow(cand_q, cnt_q, c);
            cnt_d  = len_inc(cnt_q);
          end else begin
            a_v    = 1'b1;
            a_res  = id_res;
            use_bc = 1'b1;
          end
        end
        M_INT: begin
          if (is_digit) begin
            cnt_d = len_inc(cnt_q);
          end else begin
            a_v    = 1'b1;
            use_bc = 1'b1;
          end
        end
        M_STRING: begin
          a_v = 1'b1;
          if (c == "\"") begin
            a_res  = mk(KIND_STRING, 5'd0, tsl_q, tsc_q, len_out(cnt_q), ERR_NONE, 8'h00);
            mode_d = M_IDLE;
          end else if (c == 8'h0a) begin
            a_res  = mk(KIND_ERROR, 5'd0, tsl_q, tsc_q, 16'd0, ERR_UNTERM_STR, 8'h00);
            mode_d = M_ERROR;
          end else begin
            a_v   = 1'b0;
            cnt_d = len_inc(cnt_q);
          end
        end
        M_MINUS: begin
          a_v = 1'b1;
          if (c == ">") begin
            a_res  = mk(KIND_ARROW, 5'd0, tsl_q, tsc_q, 16'd2, ERR_NONE, 8'h00);
            mode_d = M_IDLE;
          end else begin
            a_res  = mk(KIND_MINUS, 5'd0, tsl_q, tsc_q, 16'd1, ERR_NONE, 8'h00);
            use_bc = 1'b1;
          end
        end
        M_EQ: begin
          a_v = 1'b1;
          if (c == "=") begin
            a_res  = mk(KIND_EQEQ, 5'd0, tsl_q, tsc_q, 16'd2, ERR_NONE, 8'h00);
            mode_d = M_IDLE;
          end else begin
            a_res  = mk(KIND_ASSIGN, 5'd0, tsl_q, tsc_q, 16'd1, ERR_NONE, 8'h00);
            use_bc = 1'b1;
          end
        end
        M_BANG: begin
          a_v = 1'b1;
          if (c == "=") begin
            a_res  = mk(KIND_NOTEQ, 5'd0, tsl_q, tsc_q, 16'd2, ERR_NONE, 8'h00);
            mode_d = M_IDLE;
          end else begin
            a_res  = mk(KIND_ERROR, 5'd0, tsl_q, tsc_q, 16'd0, ERR_UNEXPECTED, "!");
            mode_d = M_ERROR;
          end
        end
        M_SLASH: begin
          if (c == "/") begin
            mode_d = M_COMMENT;
          end else begin
            a_v    = 1'b1;
            a_res  = mk(KIND_ERROR, 5'd0, tsl_q, tsc_q, 16'd0, ERR_UNEXPECTED, "/");
            mode_d = M_ERROR;
          end
        end
        M_COMMENT: begin
          if (c == 8'h0a) begin
            mode_d = M_IDLE;
          end
        end
        M_ERROR: mode_d = M_ERROR;
        default: use_bc = 1'b1;
      endcase
      if (use_bc) begin
        mode_d = bc_mode;
        cnt_d  = bc_cnt;
        cand_d = bc_cand;
        tsl_d  = line_q;
        tsc_d  = col_q;
        b_v    = bc_v;
      end
      if (c == 8'h0a) begin
        col_d  = POSITION_BITS'(1);
        line_d = pos_inc(line_q);
      end else begin
        col_d  = pos_inc(col_q);
      end
    end
  end

  always_comb begin
    ent_new.two = a_v && b_v;
    ent_new.r0  = a_v ? a_res : b_res;
    ent_new.r1  = b_res;
    ent_new.r0.last = !(a_v && b_v);
    ent_new.r1.last = 1'b1;
  end

  assign push     = accept && (a_v || b_v);
  assign out_xfer = out_o.valid && out_o.ready;
  assign pop      = out_xfer && (sub_q == ent_q[rd_q].two);
  assign fill_d   = fill_q + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      line_q <= POSITION_BITS'(1);
      col_q  <= POSITION_BITS'(1);
      tsl_q  <= POSITION_BITS'(1);
      tsc_q  <= POSITION_BITS'(1);
      cnt_q  <= '0;
      cand_q <= '1;
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      sub_q  <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (accept) begin
        mode_q <= mode_d;
        line_q <= line_d;
        col_q  <= col_d;
        tsl_q  <= tsl_d;
        tsc_q  <= tsc_d;
        cnt_q  <= cnt_d;
        cand_q <= cand_d;
      end
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q  <= ~rd_q;
        sub_q <= 1'b0;
      end else if (out_xfer) begin
        sub_q <= 1'b1;
      end
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_q] <= ent_new;
    end
  end

  result_t head;
  assign head = sub_q ? ent_q[rd_q].r1 : ent_q[rd_q].r0;

  assign out_o.valid         = (fill_q != 2'd0);
  assign out_o.kind          = head.kind;
  assign out_o.keyword_index = head.keyword_index;
  assign out_o.start_line    = head.start_line;
  assign out_o.start_column  = head.start_column;
  assign out_o.token_length  = head.token_length;
  assign out_o.error_code    = head.error_code;
  assign out_o.bad_char      = head.bad_char;
  assign out_o.last          = head.last;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= 2'd2)
    else $error("token queue overfilled");

  a_second_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && !out_o.last |=> out_o.valid && sub_q)
    else $error("second token of a byte missing");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.kind == KIND_END) |-> out_o.last)
    else $error("end token not marked last");

  a_eot_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && eot |=> (mode_q == M_IDLE) && (cnt_q == '0) && (&cand_q))
    else $error("scanner not reset after end of text");

endmodule
